### rtl/lfu_pkg.sv
// Shared types and constants for the LFU table tag cache.
package lfu_pkg;

	localparam int ENTRIES     = 16;
	localparam int COUNT_BITS  = 16;
	localparam int TAG_W       = 63;
	localparam int OUT_IDX_W   = 4;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int GROUP_SIZE  = 8;
	localparam int NUM_GROUPS  = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

	typedef logic [TAG_W-1:0]      tag_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [OUT_IDX_W-1:0]  out_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_COMMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

### rtl/lfu_ctrl.sv
// Controller state machine for the LFU table tag cache.
module lfu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output lfu_pkg::cmd_t  cmd
);

	lfu_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lfu_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = lfu_pkg::ST_COMMIT;
				end
			end
			lfu_pkg::ST_COMMIT: begin
				state_nxt = lfu_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = lfu_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			lfu_pkg::ST_IDLE: begin
				cmd.capture = start;
			end
			lfu_pkg::ST_COMMIT: begin
				busy       = 1'b1;
				cmd.commit = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

### rtl/lfu_dp.sv
// Datapath for the LFU table tag cache: tag/count storage, compare, min tree, update.
module lfu_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  lfu_pkg::cmd_t       cmd,
	input  lfu_pkg::tag_t       table_offset,
	output logic                done,
	output logic                hit,
	output lfu_pkg::out_idx_t   entry_index
);

	lfu_pkg::tag_t   tags_q   [lfu_pkg::ENTRIES];
	lfu_pkg::count_t counts_q [lfu_pkg::ENTRIES];

	// stage 1: captured request, match result, per-group minimum
	lfu_pkg::tag_t   tag_s1;
	logic            hit_s1;
	lfu_pkg::idx_t   hit_idx_s1;
	lfu_pkg::count_t grp_min_s1 [lfu_pkg::NUM_GROUPS];
	lfu_pkg::idx_t   grp_idx_s1 [lfu_pkg::NUM_GROUPS];

	logic            done_q;
	logic            hit_q;
	lfu_pkg::idx_t   idx_q;

	// combinational
	logic            match_any;
	lfu_pkg::idx_t   match_idx;
	lfu_pkg::count_t grp_min  [lfu_pkg::NUM_GROUPS];
	lfu_pkg::idx_t   grp_idx  [lfu_pkg::NUM_GROUPS];
	lfu_pkg::count_t vic_min;
	lfu_pkg::idx_t   vic_idx;
	lfu_pkg::count_t inc_cnt;
	logic            sat;
	logic [lfu_pkg::IDX_W+lfu_pkg::OUT_IDX_W-1:0] idx_wide;

	// parallel tag compare, lowest index wins
	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		for (int k = lfu_pkg::ENTRIES - 1; k >= 0; k--) begin
			if (tags_q[k] == table_offset) begin
				match_any = 1'b1;
				match_idx = lfu_pkg::IDX_W'(k);
			end
		end
	end

	// first tree level: min within each group, strict < keeps lowest index
	always_comb begin
		for (int g = 0; g < lfu_pkg::NUM_GROUPS; g++) begin
			grp_min[g] = counts_q[g * lfu_pkg::GROUP_SIZE];
			grp_idx[g] = lfu_pkg::IDX_W'(g * lfu_pkg::GROUP_SIZE);
			for (int j = 1; j < lfu_pkg::GROUP_SIZE; j++) begin
				if ((g * lfu_pkg::GROUP_SIZE + j) < lfu_pkg::ENTRIES) begin
					if (counts_q[lfu_pkg::IDX_W'(g * lfu_pkg::GROUP_SIZE + j)] < grp_min[g]) begin
						grp_min[g] = counts_q[lfu_pkg::IDX_W'(g * lfu_pkg::GROUP_SIZE + j)];
						grp_idx[g] = lfu_pkg::IDX_W'(g * lfu_pkg::GROUP_SIZE + j);
					end
				end
			end
		end
	end

	// second tree level over registered group winners
	always_comb begin
		vic_min = grp_min_s1[0];
		vic_idx = grp_idx_s1[0];
		for (int g = 1; g < lfu_pkg::NUM_GROUPS; g++) begin
			if (grp_min_s1[g] < vic_min) begin
				vic_min = grp_min_s1[g];
				vic_idx = grp_idx_s1[g];
			end
		end
	end

	assign inc_cnt  = counts_q[hit_idx_s1] + lfu_pkg::count_t'(1);
	assign sat      = (inc_cnt == '1);
	assign idx_wide = {{lfu_pkg::OUT_IDX_W{1'b0}}, idx_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_s1     <= table_offset;
			hit_s1     <= match_any;
			hit_idx_s1 <= match_idx;
			for (int g = 0; g < lfu_pkg::NUM_GROUPS; g++) begin
				grp_min_s1[g] <= grp_min[g];
				grp_idx_s1[g] <= grp_idx[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < lfu_pkg::ENTRIES; k++) begin
				tags_q[k]   <= '0;
				counts_q[k] <= '0;
			end
		end else if (cmd.commit) begin
			if (hit_s1) begin
				for (int k = 0; k < lfu_pkg::ENTRIES; k++) begin
					if (sat) begin
						if (lfu_pkg::IDX_W'(k) == hit_idx_s1) begin
							counts_q[k] <= inc_cnt >> 1;
						end else begin
							counts_q[k] <= counts_q[k] >> 1;
						end
					end else if (lfu_pkg::IDX_W'(k) == hit_idx_s1) begin
						counts_q[k] <= inc_cnt;
					end
				end
			end else begin
				tags_q[vic_idx]   <= tag_s1;
				counts_q[vic_idx] <= lfu_pkg::count_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q <= hit_s1;
			idx_q <= hit_s1 ? hit_idx_s1 : vic_idx;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign entry_index = idx_wide[lfu_pkg::OUT_IDX_W-1:0];

endmodule

### rtl/lfu_table_tag_cache_top.sv
// Top level of the LFU table tag cache: controller plus datapath.
//
// Fully associative tag cache with least-frequently-used replacement. A word
// (table_offset) is taken at a rising edge where start is high and busy is
// low. Each word has a capture step and an update step: the accept edge
// compares the offset against all stored tags and registers the per-group
// count minimum (groups of 8), the next edge finishes the minimum search and
// updates the tag and count registers. busy is high only in the update, so
// no word is taken during it. The result (hit, entry_index) appears in the
// cycle after the update, marked by done for exactly one cycle; the receiver
// cannot stall it and a new start may be issued in that same cycle.
// On a hit the lowest matching entry's count increments; reaching the count's
// all-ones value halves every count. On a miss the entry with the smallest
// count (lowest index on ties) takes the new tag with a count of 1. There is
// no valid bit: tags reset to zero, so a zero offset hits an empty entry.
// entry_index carries the low 4 bits of the entry number.
module lfu_table_tag_cache_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lfu_pkg::TAG_W-1:0]    table_offset,
	output logic                         busy,
	output logic                         done,
	output logic                         hit,
	output logic [lfu_pkg::OUT_IDX_W-1:0] entry_index
);

	lfu_pkg::cmd_t cmd;

	lfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	lfu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.table_offset (table_offset),
		.done         (done),
		.hit          (hit),
		.entry_index  (entry_index)
	);

endmodule

### tb/sv/lfu_table_tag_cache_top_tb.sv
// Testbench for the LFU table tag cache: directed, hot entry and random lookups.
module lfu_table_tag_cache_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// About 900 words in all. The slowest word is a full sender gap (up to MAX_GAP)
	// plus the lookup, and the watchdog gives a correct run several times the
	// time that this adds up to.
	localparam int              CYCLE_LIMIT = 400_000;
	localparam int              POOL_SIZE   = 24;
	localparam int              MAX_GAP     = 40;
	localparam int              HOT_HITS    = 150;
	localparam lfu_pkg::count_t COUNT_MAX   = '1;

	// One predicted lookup result.
	typedef struct {
		logic              was_hit;
		lfu_pkg::out_idx_t index;
	} lookup_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	lfu_pkg::tag_t     table_offset = '0;
	logic              busy;
	logic              done;
	logic              hit;
	lfu_pkg::out_idx_t entry_index;

	// Shadow copy of the cache contents, updated at each accepted word.
	lfu_pkg::tag_t     tag_store [lfu_pkg::ENTRIES];
	lfu_pkg::count_t   use_count [lfu_pkg::ENTRIES];

	// Predicted results, oldest first.
	lookup_t           pending_lookups[$];
	int                error_count = 0;
	int                sender_idle_pct = 0;

	// Offsets reused by the random traffic so that hits and LFU evictions happen.
	lfu_pkg::tag_t     offset_pool [POOL_SIZE];

	lfu_table_tag_cache_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.table_offset (table_offset),
		.busy         (busy),
		.done         (done),
		.hit          (hit),
		.entry_index  (entry_index)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cache predictor: fully associative compare, lowest match wins. A hit bumps the
	// count and halves every count when it reaches all ones. A miss takes the entry
	// with the smallest count (lowest index on ties) and sets its count to 1.
	function automatic lookup_t cache_lookup(input lfu_pkg::tag_t t);
		lookup_t         r;
		int              victim;
		lfu_pkg::count_t least;
		victim = -1;
		for (int k = 0; k < lfu_pkg::ENTRIES; k++) begin
			if (victim < 0 && tag_store[k] == t)
				victim = k;
		end
		if (victim >= 0) begin
			use_count[victim] = use_count[victim] + 1'b1;
			if (use_count[victim] == COUNT_MAX) begin
				for (int k = 0; k < lfu_pkg::ENTRIES; k++)
					use_count[k] = use_count[k] >> 1;
			end
			r.was_hit = 1'b1;
		end else begin
			victim = 0;
			least = use_count[0];
			for (int k = 1; k < lfu_pkg::ENTRIES; k++) begin
				if (use_count[k] < least) begin
					least = use_count[k];
					victim = k;
				end
			end
			tag_store[victim] = t;
			use_count[victim] = lfu_pkg::count_t'(1);
			r.was_hit = 1'b0;
		end
		r.index = lfu_pkg::out_idx_t'(victim);
		return r;
	endfunction

	// Random offset over the whole 63-bit range; often shifted down so that small
	// values show up as well as ones with the top bits set.
	function automatic lfu_pkg::tag_t random_offset();
		lfu_pkg::tag_t v;
		v = lfu_pkg::tag_t'({$urandom, $urandom});
		if ($urandom_range(1) == 1)
			v = v >> $urandom_range(62);
		return v;
	endfunction

	// Present one word and hold start until it is taken. start is left high so a
	// following word goes out back to back; gaps lower it.
	task automatic send_word(input lfu_pkg::tag_t t);
		start <= 1'b1;
		table_offset <= t;
		do
			@(posedge clk);
		while (busy);
		pending_lookups.push_back(cache_lookup(t));
	endtask

	// Random gap before the next word, driven by the current sender idle percentage.
	// The offset bus carries junk while start is low.
	task automatic sender_gap();
		int n;
		n = 0;
		while (n < MAX_GAP && $urandom_range(99) < sender_idle_pct)
			n++;
		if (n > 0) begin
			start <= 1'b0;
			table_offset <= random_offset();
			repeat (n) @(posedge clk);
		end
	endtask

	// Result checker: every done strobe is matched against the oldest prediction.
	always @(posedge clk) begin
		lookup_t exp_r;
		if (arst_n && done) begin
			if (pending_lookups.size() == 0) begin
				$error("unexpected result: hit %0b entry_index %0d", hit, entry_index);
				error_count++;
			end else begin
				exp_r = pending_lookups.pop_front();
				if (hit !== exp_r.was_hit) begin
					$error("hit mismatch: expected %0b actual %0b", exp_r.was_hit, hit);
					error_count++;
				end
				if (entry_index !== exp_r.index) begin
					$error("entry_index mismatch: expected %0d actual %0d",
						exp_r.index, entry_index);
					error_count++;
				end
			end
		end
	end

	// Directed: zero offset on the empty cache, field extremes, filling all entries,
	// LFU eviction with ties, repeat hits and a zero offset after the table is full.
	task automatic test_directed();
		sender_idle_pct = 0;
		send_word('0);                          // zero hits the empty entry 0
		send_word('0);                          // and again, count goes to 2
		send_word(lfu_pkg::tag_t'(1));
		send_word('1);                          // all-ones offset
		send_word(lfu_pkg::tag_t'(1) << (lfu_pkg::TAG_W - 1));    // top bit only
		send_word(lfu_pkg::tag_t'({(lfu_pkg::TAG_W+1)/2{2'b01}}));
		send_word(lfu_pkg::tag_t'({(lfu_pkg::TAG_W+1)/2{2'b10}}));
		send_word('1);                          // hit on all-ones
		for (int k = 0; k < 10; k++)
			send_word(lfu_pkg::tag_t'(64'h100 + k));     // fill the rest of the table
		send_word(lfu_pkg::tag_t'(64'h1000));            // table full: evicts lowest count
		send_word(lfu_pkg::tag_t'(64'h1001));
		send_word('0);                          // zero tag is still in entry 0: hits
		send_word(lfu_pkg::tag_t'(1));
		send_word(lfu_pkg::tag_t'(64'h1000));
		send_word('1);
	endtask

	// Hot entry: hammer one offset so its count climbs well above the rest, then
	// check that misses keep evicting the colder entries around it.
	task automatic test_hot_entry();
		lfu_pkg::tag_t hot;
		sender_idle_pct = 0;
		hot = lfu_pkg::tag_t'(64'h7ABC_DEF0_1234_5678);
		send_word(hot);
		for (int i = 0; i < HOT_HITS; i++)
			send_word(hot);
		send_word(lfu_pkg::tag_t'(64'h2222));
		send_word(lfu_pkg::tag_t'(64'h3333));
		send_word(hot);
		send_word('0);
	endtask

	// Random traffic: mostly offsets from a skewed pool so some entries get hot and
	// others are evicted, plus fresh offsets, zero offsets and pool refreshes.
	task automatic test_random_traffic(input int idle_pct, input int n_words);
		int            sel;
		lfu_pkg::tag_t t;
		sender_idle_pct = idle_pct;
		for (int i = 0; i < n_words; i++) begin
			sel = $urandom_range(99);
			if (sel < 80) begin
				t = offset_pool[$urandom_range($urandom_range(POOL_SIZE - 1))];
			end else if (sel < 93) begin
				t = random_offset();
			end else if (sel < 96) begin
				t = '0;
			end else begin
				offset_pool[$urandom_range(POOL_SIZE - 1)] = random_offset();
				t = offset_pool[$urandom_range(POOL_SIZE - 1)];
			end
			sender_gap();
			send_word(t);
		end
	endtask

	// Watchdog.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("lfu_table_tag_cache_top test failed");
		$finish;
	end

	initial begin
		int drain_guard;
		for (int k = 0; k < lfu_pkg::ENTRIES; k++) begin
			tag_store[k] = '0;
			use_count[k] = '0;
		end
		for (int k = 0; k < POOL_SIZE; k++)
			offset_pool[k] = random_offset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_hot_entry();
		test_random_traffic(0, 240);    // back to back
		test_random_traffic(75, 240);   // sender mostly idle
		test_random_traffic(7, 240);    // occasional gaps

		start <= 1'b0;
		drain_guard = 0;
		while (pending_lookups.size() != 0 && drain_guard < 1000) begin
			@(posedge clk);
			drain_guard++;
		end
		// then keep clocking to catch any stray done
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending_lookups.size() == 0) begin
			$display("lfu_table_tag_cache_top test passed");
		end else begin
			if (pending_lookups.size() != 0)
				$error("%0d results never arrived", pending_lookups.size());
			$display("lfu_table_tag_cache_top test failed");
		end
		$finish;
	end

endmodule
